FILE: rtl/core/fkq_pkg.sv
// Shared constants, types and helper functions for the focused key queue router.
package fkq_pkg;

    localparam int MAX_WIN    = 8;
    localparam int RING_DEPTH = 256;
    localparam int ID_BITS    = 16;

    localparam int SLOT_W    = (MAX_WIN > 1) ? $clog2(MAX_WIN) : 1;
    localparam int CNT_W     = $clog2(MAX_WIN + 1);
    localparam int PTR_W     = $clog2(RING_DEPTH);
    localparam int KEY_DEPTH = MAX_WIN * RING_DEPTH;
    localparam int KEY_AW    = $clog2(KEY_DEPTH);

    // Close requests for an owner id at or below this value are rejected with a failed status.
    localparam int CLOSE_MIN_ID = 1;

    typedef enum logic [2:0] {
        OP_OPEN  = 3'd0,
        OP_CLOSE = 3'd1,
        OP_FOCUS = 3'd2,
        OP_PUSH  = 3'd3,
        OP_POP   = 3'd4
    } op_t;

    typedef struct packed {
        logic [ID_BITS-1:0] owner;
        logic [PTR_W-1:0]   wp;
        logic [PTR_W-1:0]   rp;
    } slot_rec_t;

    localparam int REC_W = $bits(slot_rec_t);

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (int'(p) + 1 >= RING_DEPTH)
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    function automatic logic [KEY_AW-1:0] key_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [PTR_W-1:0] ptr);
        return KEY_AW'(slot) * KEY_AW'(RING_DEPTH) + KEY_AW'(ptr);
    endfunction

endpackage

FILE: rtl/core/fkq_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
module fkq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/focused_key_queue_router.sv
// Top level of the focused key queue router: window list, focus and per-window key rings.
//
//  Channel  | Handshake            | Fields
//  ---------+----------------------+------------------------------------------------
//  command  | start, busy          | opcode, owner_id, key_code, list_position
//  result   | done (one-cycle)     | popped_key, status, window_total
//
// Open, focus, undefined opcodes, push with no focus and a close or pop rejected at once
// finish in the execute state. Push otherwise reads the slot record memory, then writes
// back the record and the key unless the ring is full. Close and pop visit k (1 to
// MAX_WIN) list entries; one slot record is read per cycle. A pop that returns a key then
// reads it from the key memory in the pop key state before its result.
// Reset clears the list, count, focus and slot flags at once; no clearing pass is needed.
// A new item is taken in the cycle the done strobe shows; the receiver cannot stall.
module focused_key_queue_router (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  opcode,
    input  logic [fkq_pkg::ID_BITS-1:0] owner_id,
    input  logic [7:0]                  key_code,
    input  logic [2:0]                  list_position,
    output logic                        done,
    output logic [7:0]                  popped_key,
    output logic                        status,
    output logic [3:0]                  window_total
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_CHECK,
        S_POPKEY
    } state_t;

    state_t                        state_reg, state_next;
    fkq_pkg::op_t                  op_reg, op_next;
    logic [fkq_pkg::ID_BITS-1:0]   id_reg, id_next;
    logic [7:0]                    key_reg, key_next;
    logic [2:0]                    pos_reg, pos_next;
    logic [fkq_pkg::SLOT_W-1:0]    idx_reg, idx_next;
    logic [fkq_pkg::SLOT_W-1:0]    slot_reg, slot_next;
    logic [fkq_pkg::SLOT_W-1:0]    order_reg [fkq_pkg::MAX_WIN];
    logic [fkq_pkg::SLOT_W-1:0]    order_next [fkq_pkg::MAX_WIN];
    logic [fkq_pkg::MAX_WIN-1:0]   slot_busy_reg, slot_busy_next;
    logic [fkq_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [fkq_pkg::SLOT_W-1:0]    focus_slot_reg, focus_slot_next;
    logic                          focus_valid_reg, focus_valid_next;
    logic                          done_reg, done_next;
    logic [7:0]                    popped_key_reg, popped_key_next;
    logic                          status_reg, status_next;
    logic [3:0]                    window_total_reg, window_total_next;

    logic [fkq_pkg::SLOT_W-1:0]    list_shift [fkq_pkg::MAX_WIN];
    logic [fkq_pkg::SLOT_W-1:0]    list_idx;
    logic [fkq_pkg::SLOT_W-1:0]    list_val;
    logic [fkq_pkg::SLOT_W-1:0]    scan_next;
    logic [fkq_pkg::SLOT_W-1:0]    free_slot;
    logic                          pos_ok;
    logic                          scan_last;

    logic                          slot_we;
    logic [fkq_pkg::SLOT_W-1:0]    slot_waddr;
    fkq_pkg::slot_rec_t            slot_wdata;
    logic [fkq_pkg::SLOT_W-1:0]    slot_raddr;
    fkq_pkg::slot_rec_t            slot_rdata;
    logic [fkq_pkg::PTR_W-1:0]     wp_after;

    logic                          key_we;
    logic [fkq_pkg::KEY_AW-1:0]    key_waddr;
    logic [fkq_pkg::KEY_AW-1:0]    key_raddr;
    logic [7:0]                    key_rdata;

    logic                          finish;
    logic                          fail;
    logic                          got_key;

    fkq_ram #(
        .WIDTH (fkq_pkg::REC_W),
        .DEPTH (fkq_pkg::MAX_WIN),
        .AW    (fkq_pkg::SLOT_W)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    fkq_ram #(
        .WIDTH (8),
        .DEPTH (fkq_pkg::KEY_DEPTH),
        .AW    (fkq_pkg::KEY_AW)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_reg),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign popped_key   = popped_key_reg;
    assign status       = status_reg;
    assign window_total = window_total_reg;

    assign pos_ok    = (int'(pos_reg) < int'(count_reg));
    assign scan_last = (int'(idx_reg) + 1 >= int'(count_reg));
    assign scan_next = (int'(idx_reg) == fkq_pkg::MAX_WIN - 1) ? '0
                                                              : idx_reg + fkq_pkg::SLOT_W'(1);
    assign wp_after  = fkq_pkg::ring_next(slot_rdata.wp);

    always_comb
    begin
        list_idx = '0;
        if (state_reg == S_EXEC && op_reg == fkq_pkg::OP_FOCUS && pos_ok)
        begin
            list_idx = fkq_pkg::SLOT_W'(pos_reg);
        end
        else if (state_reg == S_CHECK)
        begin
            list_idx = scan_next;
        end
    end

    assign list_val = order_reg[list_idx];

    always_comb
    begin
        free_slot = '0;
        for (int i = fkq_pkg::MAX_WIN - 1; i >= 0; i--)
        begin
            if (!slot_busy_reg[i])
            begin
                free_slot = fkq_pkg::SLOT_W'(i);
            end
        end
    end

    // The list with the entry at the scan index removed and the tail moved up.
    always_comb
    begin
        for (int i = 0; i < fkq_pkg::MAX_WIN; i++)
        begin
            if (i >= int'(idx_reg) && i < fkq_pkg::MAX_WIN - 1)
            begin
                list_shift[i] = order_reg[(i + 1) % fkq_pkg::MAX_WIN];
            end
            else
            begin
                list_shift[i] = order_reg[i];
            end
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        op_next           = op_reg;
        id_next           = id_reg;
        key_next          = key_reg;
        pos_next          = pos_reg;
        idx_next          = idx_reg;
        slot_next         = slot_reg;
        order_next        = order_reg;
        slot_busy_next    = slot_busy_reg;
        count_next        = count_reg;
        focus_slot_next   = focus_slot_reg;
        focus_valid_next  = focus_valid_reg;
        done_next         = 1'b0;
        popped_key_next   = popped_key_reg;
        status_next       = status_reg;
        window_total_next = window_total_reg;
        slot_we           = 1'b0;
        slot_waddr        = slot_reg;
        slot_wdata        = slot_rdata;
        slot_raddr        = slot_reg;
        key_we            = 1'b0;
        key_waddr         = fkq_pkg::key_addr(slot_reg, slot_rdata.wp);
        key_raddr         = fkq_pkg::key_addr(slot_reg, slot_rdata.rp);
        finish            = 1'b0;
        fail              = 1'b0;
        got_key           = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = fkq_pkg::op_t'(opcode);
                    id_next    = owner_id;
                    key_next   = key_code;
                    pos_next   = list_position;
                    idx_next   = '0;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (op_reg)
                    fkq_pkg::OP_OPEN:
                    begin
                        finish = 1'b1;
                        if (int'(count_reg) >= fkq_pkg::MAX_WIN)
                        begin
                            fail = 1'b1;
                        end
                        else
                        begin
                            slot_we          = 1'b1;
                            slot_waddr       = free_slot;
                            slot_wdata.owner = id_reg;
                            slot_wdata.wp    = '0;
                            slot_wdata.rp    = '0;
                            slot_busy_next[free_slot] = 1'b1;
                            order_next[fkq_pkg::SLOT_W'(count_reg)] = free_slot;
                            count_next = count_reg + fkq_pkg::CNT_W'(1);
                            if (!focus_valid_reg)
                            begin
                                focus_slot_next  = free_slot;
                                focus_valid_next = 1'b1;
                            end
                        end
                    end
                    fkq_pkg::OP_CLOSE:
                    begin
                        if (id_reg <= fkq_pkg::ID_BITS'(fkq_pkg::CLOSE_MIN_ID) ||
                            count_reg == '0)
                        begin
                            finish = 1'b1;
                            fail   = 1'b1;
                        end
                        else
                        begin
                            slot_raddr = list_val;
                            slot_next  = list_val;
                            state_next = S_CHECK;
                        end
                    end
                    fkq_pkg::OP_FOCUS:
                    begin
                        finish = 1'b1;
                        if (!pos_ok)
                        begin
                            fail = 1'b1;
                        end
                        else
                        begin
                            focus_slot_next  = list_val;
                            focus_valid_next = 1'b1;
                        end
                    end
                    fkq_pkg::OP_PUSH:
                    begin
                        if (!focus_valid_reg)
                        begin
                            finish = 1'b1;
                            fail   = 1'b1;
                        end
                        else
                        begin
                            slot_raddr = focus_slot_reg;
                            slot_next  = focus_slot_reg;
                            state_next = S_CHECK;
                        end
                    end
                    fkq_pkg::OP_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            finish = 1'b1;
                            fail   = 1'b1;
                        end
                        else
                        begin
                            slot_raddr = list_val;
                            slot_next  = list_val;
                            state_next = S_CHECK;
                        end
                    end
                    default:
                    begin
                        finish = 1'b1;
                        fail   = 1'b1;
                    end
                endcase
            end
            S_CHECK:
            begin
                case (op_reg)
                    fkq_pkg::OP_CLOSE:
                    begin
                        if (slot_rdata.owner == id_reg)
                        begin
                            finish     = 1'b1;
                            order_next = list_shift;
                            count_next = count_reg - fkq_pkg::CNT_W'(1);
                            slot_busy_next[slot_reg] = 1'b0;
                            if (focus_valid_reg && focus_slot_reg == slot_reg)
                            begin
                                if (int'(count_reg) > 1)
                                begin
                                    focus_slot_next = list_shift[0];
                                end
                                else
                                begin
                                    focus_valid_next = 1'b0;
                                    focus_slot_next  = '0;
                                end
                            end
                        end
                        else if (scan_last)
                        begin
                            finish = 1'b1;
                            fail   = 1'b1;
                        end
                        else
                        begin
                            idx_next   = scan_next;
                            slot_raddr = list_val;
                            slot_next  = list_val;
                        end
                    end
                    fkq_pkg::OP_PUSH:
                    begin
                        finish = 1'b1;
                        if (wp_after == slot_rdata.rp)
                        begin
                            fail = 1'b1;
                        end
                        else
                        begin
                            key_we        = 1'b1;
                            slot_we       = 1'b1;
                            slot_wdata.wp = wp_after;
                        end
                    end
                    fkq_pkg::OP_POP:
                    begin
                        if ((slot_rdata.owner == id_reg || slot_rdata.owner == '0) &&
                            slot_rdata.rp != slot_rdata.wp)
                        begin
                            slot_we       = 1'b1;
                            slot_wdata.rp = fkq_pkg::ring_next(slot_rdata.rp);
                            state_next    = S_POPKEY;
                        end
                        else if (scan_last)
                        begin
                            finish = 1'b1;
                            fail   = 1'b1;
                        end
                        else
                        begin
                            idx_next   = scan_next;
                            slot_raddr = list_val;
                            slot_next  = list_val;
                        end
                    end
                    default:
                    begin
                        finish = 1'b1;
                        fail   = 1'b1;
                    end
                endcase
            end
            S_POPKEY:
            begin
                finish  = 1'b1;
                got_key = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish)
        begin
            state_next        = S_IDLE;
            done_next         = 1'b1;
            status_next       = fail;
            popped_key_next   = got_key ? key_rdata : 8'd0;
            window_total_next = 4'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            op_reg           <= fkq_pkg::OP_OPEN;
            id_reg           <= '0;
            key_reg          <= '0;
            pos_reg          <= '0;
            idx_reg          <= '0;
            slot_reg         <= '0;
            for (int i = 0; i < fkq_pkg::MAX_WIN; i++)
            begin
                order_reg[i] <= '0;
            end
            slot_busy_reg    <= '0;
            count_reg        <= '0;
            focus_slot_reg   <= '0;
            focus_valid_reg  <= 1'b0;
            done_reg         <= 1'b0;
            popped_key_reg   <= '0;
            status_reg       <= 1'b0;
            window_total_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            op_reg           <= op_next;
            id_reg           <= id_next;
            key_reg          <= key_next;
            pos_reg          <= pos_next;
            idx_reg          <= idx_next;
            slot_reg         <= slot_next;
            order_reg        <= order_next;
            slot_busy_reg    <= slot_busy_next;
            count_reg        <= count_next;
            focus_slot_reg   <= focus_slot_next;
            focus_valid_reg  <= focus_valid_next;
            done_reg         <= done_next;
            popped_key_reg   <= popped_key_next;
            status_reg       <= status_next;
            window_total_reg <= window_total_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg != S_IDLE))
        else $error("Result strobe without an item in progress.");

    assert property (@(posedge clk) disable iff (!rst_n)
        focus_valid_reg == (count_reg != '0))
        else $error("Focus flag disagrees with the window count.");

    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(slot_busy_reg) == int'(count_reg))
        else $error("Occupied slots disagree with the window count.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && popped_key_reg != 8'd0) |-> !status_reg)
        else $error("A key was returned on a failed item.");

endmodule
